@@ hw/rtl/cigar_string_parser_macros.svh @@
// Assertion macros used by the result queue.
`ifndef CIGAR_STRING_PARSER_MACROS_SVH
`define CIGAR_STRING_PARSER_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CSP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// Implication whose consequence is checked in the next cycle.
`define CSP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

@@ hw/rtl/csp_pkg.sv @@
package csp_pkg;

	// Width of the internal reference and read positions and of the run count.
	localparam int POS_W = 32;
	localparam int FIELD_W = 32;

	// Depth of the result queue; it must hold at least two results.
	localparam int RES_DEPTH = 4;

	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_M = 8'h4D;
	localparam logic [7:0] CH_D = 8'h44;
	localparam logic [7:0] CH_N = 8'h4E;
	localparam logic [7:0] CH_I = 8'h49;
	localparam logic [7:0] CH_S = 8'h53;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [FIELD_W-1:0] field_t;

	typedef enum logic [2:0] {
		KIND_MATCH    = 3'd0,
		KIND_DELETION = 3'd1,
		KIND_INSERT   = 3'd2,
		KIND_END_OK   = 3'd3,
		KIND_END_FAIL = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t  kind;
		field_t ref_start;
		field_t ref_end;
		field_t read_offset;
		field_t run_length;
		logic   last_of_run;
	} res_t;

	// Up to two results written into the queue in the same cycle.
	typedef struct packed {
		logic [1:0] num;
		res_t       res0;
		res_t       res1;
	} res_push_t;

	function automatic field_t pos_to_field(pos_t p);
		logic [63:0] wide;
		wide = 64'(p);
		return wide[FIELD_W-1:0];
	endfunction

	function automatic pos_t field_to_pos(field_t f);
		logic [63:0] wide;
		wide = 64'(f);
		return wide[POS_W-1:0];
	endfunction

endpackage

@@ hw/rtl/csp_core.sv @@
module csp_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               first,
	input  csp_pkg::field_t    ref_origin,
	input  logic [7:0]         ch,
	input  logic               last,
	output csp_pkg::res_push_t push
);
	import csp_pkg::*;

	pos_t ref_q, read_q, pend_q;
	logic fail_q;

	pos_t base_ref, base_read, run;
	logic base_fail;
	pos_t ref_d, read_d, pend_d;
	logic fail_d;
	pos_t pend_acc;
	logic is_digit, elem_v;
	res_t elem, done;

	always_comb begin
		base_ref  = first ? field_to_pos(ref_origin) : ref_q;
		base_read = first ? '0 : read_q;
		run       = first ? '0 : pend_q;
		base_fail = first ? 1'b0 : fail_q;
		is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
		// Times ten as two shifts and an add; digit value is the low nibble.
		pend_acc  = POS_W'((run << 3) + (run << 1) + POS_W'(ch[3:0]));

		ref_d  = base_ref;
		read_d = base_read;
		pend_d = run;
		fail_d = base_fail;
		elem_v = 1'b0;
		elem   = '0;
		elem.ref_start   = pos_to_field(base_ref);
		elem.ref_end     = pos_to_field(POS_W'(base_ref + run));
		elem.read_offset = pos_to_field(base_read);
		elem.run_length  = pos_to_field(run);

		if (!base_fail) begin
			if (is_digit) begin
				pend_d = pend_acc;
			end else begin
				pend_d = '0;
				case (ch)
					CH_M: begin
						elem_v       = 1'b1;
						elem.kind    = KIND_MATCH;
						elem.ref_end = pos_to_field(POS_W'(base_ref + run - POS_W'(1)));
						ref_d        = POS_W'(base_ref + run);
						read_d       = POS_W'(base_read + run);
					end
					CH_D: begin
						elem_v    = 1'b1;
						elem.kind = KIND_DELETION;
					end
					CH_N: begin
						ref_d = POS_W'(base_ref + run);
					end
					CH_I: begin
						elem_v    = 1'b1;
						elem.kind = KIND_INSERT;
						read_d    = POS_W'(base_read + run);
					end
					CH_S: begin
						read_d = POS_W'(base_read + run);
					end
					default: begin
						fail_d = 1'b1;
					end
				endcase
			end
		end

		done.kind        = fail_d ? KIND_END_FAIL : KIND_END_OK;
		done.ref_start   = pos_to_field(ref_d);
		done.ref_end     = pos_to_field(ref_d);
		done.read_offset = pos_to_field(read_d);
		done.run_length  = '0;
		done.last_of_run = 1'b1;
		elem.last_of_run = !last;

		push.res0 = elem_v ? elem : done;
		push.res1 = done;
		if (!advance) begin
			push.num = 2'd0;
		end else begin
			push.num = 2'(elem_v) + 2'(last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q  <= '0;
			read_q <= '0;
			pend_q <= '0;
			fail_q <= 1'b0;
		end else if (advance) begin
			ref_q  <= ref_d;
			read_q <= read_d;
			pend_q <= pend_d;
			fail_q <= fail_d;
		end
	end

endmodule

@@ hw/rtl/csp_res_fifo.sv @@
`include "cigar_string_parser_macros.svh"

module csp_res_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  csp_pkg::res_push_t push,
	output logic               space2,
	output logic               out_valid,
	input  logic               out_ready,
	output csp_pkg::res_t      out_res
);
	import csp_pkg::*;

	localparam int PTR_W = $clog2(RES_DEPTH);
	localparam int CNT_W = $clog2(RES_DEPTH + 1);

	res_t mem_q [RES_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_res   = mem_q[rd_ptr_q];
	assign space2    = (count_q <= CNT_W'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			mem_q[wr_ptr_q] <= push.res0;
		end
		if (push.num == 2'd2) begin
			mem_q[PTR_W'(wr_ptr_q + PTR_W'(1))] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= PTR_W'(wr_ptr_q + PTR_W'(push.num));
			rd_ptr_q <= PTR_W'(rd_ptr_q + PTR_W'(pop));
			count_q  <= CNT_W'(count_q + CNT_W'(push.num) - CNT_W'(pop));
		end
	end

	`CSP_ASSERT_IMP(a_push_fits, clk, arst_n, push.num != 2'd0, count_q <= CNT_W'(RES_DEPTH) - CNT_W'(push.num))
	`CSP_ASSERT_IMP(a_no_triple, clk, arst_n, 1'b1, push.num != 2'd3)
	`CSP_ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && push.num == 2'd0, count_q == CNT_W'($past(count_q) - CNT_W'(1)))

endmodule

@@ hw/rtl/cigar_string_parser.sv @@
// CIGAR string parser. One CIGAR character is taken per input transfer; the character
// flagged first also loads the reference start position and clears the read position,
// the run count and the failure flag. Digits build a decimal run length, and the letters
// M, D and I each produce one element result (match interval with inclusive end,
// deletion, insertion with its read offset), while N and S only move the reference or
// read position; any other character marks the string as failed and silences further
// elements until the next first character. The character flagged last adds an end result
// (kind 3 ok, kind 4 failed) and last_of_run marks the final result of each character.
// Rate: the input accepts one character per cycle while the result queue has room for
// two results. A character is held in the input register, and its results are then
// written into the result queue, which drives the output. The output sends one result
// per cycle while out_ready is high; a character with two results (an element plus the
// end result) sends both in turn, and the four-entry result queue absorbs that burst.
// The sustained rate is one character per cycle if results average one or fewer each.
module cigar_string_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               first,
	input  logic [31:0]        ref_origin,
	input  logic [7:0]         ch,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         kind,
	output logic [31:0]        ref_start,
	output logic [31:0]        ref_end,
	output logic [31:0]        read_offset,
	output logic [31:0]        run_length,
	output logic               last_of_run
);
	import csp_pkg::*;

	// Input register stage.
	logic       valid_s1;
	logic       first_s1;
	field_t     ref_origin_s1;
	logic [7:0] ch_s1;
	logic       last_s1;

	logic      space2;
	logic      advance;
	res_push_t push;
	res_t      out_res;

	// The registered character moves on whenever the queue has room for two results,
	// which is the most one character can produce.
	assign advance  = valid_s1 && space2;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// The payload is loaded only on an accepted transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			first_s1      <= first;
			ref_origin_s1 <= ref_origin;
			ch_s1         <= ch;
			last_s1       <= last;
		end
	end

	csp_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.first      (first_s1),
		.ref_origin (ref_origin_s1),
		.ch         (ch_s1),
		.last       (last_s1),
		.push       (push)
	);

	csp_res_fifo u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.space2    (space2),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (out_res)
	);

	assign kind        = out_res.kind;
	assign ref_start   = out_res.ref_start;
	assign ref_end     = out_res.ref_end;
	assign read_offset = out_res.read_offset;
	assign run_length  = out_res.run_length;
	assign last_of_run = out_res.last_of_run;

endmodule
